// ===== sv/background_color_reply_parser_core_defines.svh =====
// ---------------------------------------------------------------------------
// Background color reply parser: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BACKGROUND_COLOR_REPLY_PARSER_CORE_DEFINES_SVH
`define BACKGROUND_COLOR_REPLY_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define BCRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BCRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bcrp_pkg.sv =====
// ---------------------------------------------------------------------------
// Background color reply parser package
// Shared types, codes and constants of the parser front, queue and back.
// ---------------------------------------------------------------------------
package bcrp_pkg;

  // Most hex digits accepted in one color field (1 to 4).
  localparam int unsigned MaxDigits = 4;
  localparam int unsigned DigitCntW = 3;

  // Depth of the queue between parser and luma pipeline.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Q16 luma weights: 0.2126, 0.7152 and 0.0722 of full scale.
  localparam logic [15:0] LumaWeightRed   = 16'd13933;
  localparam logic [15:0] LumaWeightGreen = 16'd46871;
  localparam logic [15:0] LumaWeightBlue  = 16'd4732;

  // Characters of the reply.
  localparam logic [7:0] CharR     = 8'h72;
  localparam logic [7:0] CharG     = 8'h67;
  localparam logic [7:0] CharB     = 8'h62;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharEsc   = 8'h1B;
  localparam logic [7:0] CharNul   = 8'h00;

  typedef enum logic [8:0] {
    PhS0    = 9'b000000001,
    PhS1    = 9'b000000010,
    PhS2    = 9'b000000100,
    PhS3    = 9'b000001000,
    PhRed   = 9'b000010000,
    PhGreen = 9'b000100000,
    PhBlue  = 9'b001000000,
    PhDone  = 9'b010000000,
    PhFail  = 9'b100000000
  } bcrp_phase_e;

  typedef enum logic [1:0] {
    ShadeNone  = 2'd0,
    ShadeDark  = 2'd1,
    ShadeLight = 2'd2
  } bcrp_shade_e;

  // One finished reply as handed from the parser to the luma pipeline.
  typedef struct packed {
    logic        done;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } bcrp_color_t;

endpackage

// ===== sv/bcrp_front.sv =====
// ---------------------------------------------------------------------------
// Background color reply parser: front
// Byte-wise parser that finds "rgb:" and collects three scaled hex fields.
// ---------------------------------------------------------------------------
`include "background_color_reply_parser_core_defines.svh"

module bcrp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_valid_i,
  output logic                 byte_ready_o,
  input  logic [7:0]           reply_byte_i,
  input  logic                 end_of_reply_i,
  input  logic                 space_i,
  output logic                 push_o,
  output bcrp_pkg::bcrp_color_t push_data_o
);

  bcrp_pkg::bcrp_phase_e                phase_q, phase_d;
  logic [15:0]                          acc_q, acc_d;
  logic [bcrp_pkg::DigitCntW-1:0]       cnt_q, cnt_d;
  logic [15:0]                          red_q, red_d;
  logic [15:0]                          green_q, green_d;
  logic [15:0]                          blue_q, blue_d;
  logic                                 fire;
  logic                                 hex_ok;
  logic [3:0]                           hex_val;
  logic [7:0]                           term;
  logic [15:0]                          level;

  function automatic bcrp_pkg::bcrp_phase_e search_next(
    input logic [7:0]            c,
    input logic [7:0]            want,
    input bcrp_pkg::bcrp_phase_e on_match
  );
    if (c == bcrp_pkg::CharNul) begin
      return bcrp_pkg::PhFail;
    end else if (c == want) begin
      return on_match;
    end else if (c == bcrp_pkg::CharR) begin
      return bcrp_pkg::PhS1;
    end
    return bcrp_pkg::PhS0;
  endfunction

  assign byte_ready_o = space_i;
  assign fire         = byte_valid_i && space_i;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (reply_byte_i >= 8'h30 && reply_byte_i <= 8'h39) begin
      hex_val = 4'(reply_byte_i - 8'h30);
    end else if (reply_byte_i >= 8'h61 && reply_byte_i <= 8'h66) begin
      hex_val = 4'(reply_byte_i - 8'h57);
    end else if (reply_byte_i >= 8'h41 && reply_byte_i <= 8'h46) begin
      hex_val = 4'(reply_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Left-align an n-digit field into a 16-bit fraction.
  always_comb begin
    case (cnt_q)
      3'd1:    level = {acc_q[3:0], 12'd0};
      3'd2:    level = {acc_q[7:0], 8'd0};
      3'd3:    level = {acc_q[11:0], 4'd0};
      default: level = acc_q;
    endcase
  end

  assign term = (phase_q == bcrp_pkg::PhBlue) ? bcrp_pkg::CharEsc : bcrp_pkg::CharSlash;

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    red_d   = red_q;
    green_d = green_q;
    blue_d  = blue_q;
    case (phase_q)
      bcrp_pkg::PhS0: phase_d = search_next(reply_byte_i, bcrp_pkg::CharR, bcrp_pkg::PhS1);
      bcrp_pkg::PhS1: phase_d = search_next(reply_byte_i, bcrp_pkg::CharG, bcrp_pkg::PhS2);
      bcrp_pkg::PhS2: phase_d = search_next(reply_byte_i, bcrp_pkg::CharB, bcrp_pkg::PhS3);
      bcrp_pkg::PhS3: phase_d = search_next(reply_byte_i, bcrp_pkg::CharColon,
                                            bcrp_pkg::PhRed);
      bcrp_pkg::PhRed, bcrp_pkg::PhGreen, bcrp_pkg::PhBlue: begin
        if (hex_ok) begin
          if (cnt_q >= bcrp_pkg::DigitCntW'(bcrp_pkg::MaxDigits)) begin
            phase_d = bcrp_pkg::PhFail;
          end else begin
            acc_d = {acc_q[11:0], hex_val};
            cnt_d = cnt_q + 1'b1;
          end
        end else if (reply_byte_i != term || cnt_q == '0) begin
          phase_d = bcrp_pkg::PhFail;
        end else begin
          acc_d = '0;
          cnt_d = '0;
          if (phase_q == bcrp_pkg::PhRed) begin
            red_d   = level;
            phase_d = bcrp_pkg::PhGreen;
          end else if (phase_q == bcrp_pkg::PhGreen) begin
            green_d = level;
            phase_d = bcrp_pkg::PhBlue;
          end else begin
            blue_d  = level;
            phase_d = bcrp_pkg::PhDone;
          end
        end
      end
      bcrp_pkg::PhDone: phase_d = bcrp_pkg::PhDone;
      default:          phase_d = bcrp_pkg::PhFail;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bcrp_pkg::PhS0;
      acc_q   <= '0;
      cnt_q   <= '0;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
    end else if (fire) begin
      if (end_of_reply_i) begin
        phase_q <= bcrp_pkg::PhS0;
        acc_q   <= '0;
        cnt_q   <= '0;
        red_q   <= '0;
        green_q <= '0;
        blue_q  <= '0;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        red_q   <= red_d;
        green_q <= green_d;
        blue_q  <= blue_d;
      end
    end
  end

  assign push_o            = fire && end_of_reply_i;
  assign push_data_o.done  = (phase_d == bcrp_pkg::PhDone);
  assign push_data_o.red   = red_d;
  assign push_data_o.green = green_d;
  assign push_data_o.blue  = blue_d;

  `BCRP_ASSERT_NEXT(a_reply_end_rearms, fire && end_of_reply_i,
    phase_q == bcrp_pkg::PhS0 && cnt_q == '0, "parser did not rearm after the last byte")
  `BCRP_ASSERT_NOW(a_digits_bounded, 1'b1,
    cnt_q <= bcrp_pkg::DigitCntW'(bcrp_pkg::MaxDigits), "digit count beyond the limit")

endmodule

// ===== sv/bcrp_fifo.sv =====
// ---------------------------------------------------------------------------
// Background color reply parser: queue
// Small register queue that decouples the parser from the luma pipeline.
// ---------------------------------------------------------------------------
`include "background_color_reply_parser_core_defines.svh"

module bcrp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bcrp_pkg::bcrp_color_t push_data_i,
  output logic                  space_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output bcrp_pkg::bcrp_color_t pop_data_o
);

  bcrp_pkg::bcrp_color_t             mem_q [bcrp_pkg::FifoDepth];
  logic [bcrp_pkg::FifoPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [bcrp_pkg::FifoPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [bcrp_pkg::FifoCntW-1:0]     count_q, count_d;
  logic                              do_push;
  logic                              do_pop;

  localparam logic [bcrp_pkg::FifoPtrW-1:0] LastPtr =
    bcrp_pkg::FifoPtrW'(bcrp_pkg::FifoDepth - 1);

  assign space_o    = (count_q != bcrp_pkg::FifoCntW'(bcrp_pkg::FifoDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && space_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `BCRP_ASSERT_NOW(a_push_has_room, push_i, space_o, "push into a full queue")

endmodule

// ===== sv/bcrp_back.sv =====
// ---------------------------------------------------------------------------
// Background color reply parser: back
// Two-stage luma pipeline: weighted products, then sum, threshold and output.
// ---------------------------------------------------------------------------
`include "background_color_reply_parser_core_defines.svh"

module bcrp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  bcrp_pkg::bcrp_color_t item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bcrp_pkg::bcrp_shade_e out_shade_o,
  output logic [15:0]           out_luma_o
);

  logic                  s1_valid_q;
  logic                  s1_done_q;
  logic [31:0]           prod_r_q, prod_g_q, prod_b_q;
  logic                  out_valid_q;
  bcrp_pkg::bcrp_shade_e shade_q, shade_d;
  logic [15:0]           luma_q, luma_d;
  logic [31:0]           sum;
  logic                  out_take;
  logic                  s1_take;

  assign out_take = !out_valid_q || out_ready_i;
  assign s1_take  = !s1_valid_q || out_take;
  assign pop_o    = s1_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_take) begin
      s1_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && item_valid_i) begin
      s1_done_q <= item_i.done;
      prod_r_q  <= 32'(item_i.red)   * 32'(bcrp_pkg::LumaWeightRed);
      prod_g_q  <= 32'(item_i.green) * 32'(bcrp_pkg::LumaWeightGreen);
      prod_b_q  <= 32'(item_i.blue)  * 32'(bcrp_pkg::LumaWeightBlue);
    end
  end

  // The weights add up to one, so the sum stays below 2^32.
  assign sum = prod_r_q + prod_g_q + prod_b_q;

  always_comb begin
    if (s1_done_q) begin
      luma_d  = sum[31:16];
      shade_d = sum[31] ? bcrp_pkg::ShadeLight : bcrp_pkg::ShadeDark;
    end else begin
      luma_d  = '0;
      shade_d = bcrp_pkg::ShadeNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && s1_valid_q) begin
      luma_q  <= luma_d;
      shade_q <= shade_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_shade_o = shade_q;
  assign out_luma_o  = luma_q;

  `BCRP_ASSERT_NEXT(a_failed_reply_zero, out_take && s1_valid_q && !s1_done_q,
    shade_q == bcrp_pkg::ShadeNone && luma_q == '0, "failed reply gave a nonzero result")
  `BCRP_ASSERT_NOW(a_light_means_half, out_valid_q && shade_q != bcrp_pkg::ShadeNone,
    luma_q[15] == (shade_q == bcrp_pkg::ShadeLight), "shade disagrees with luma")

endmodule

// ===== sv/background_color_reply_parser_core.sv =====
// ---------------------------------------------------------------------------
// Background color reply parser core
// Parses a terminal color reply and reports a dark or light background.
// ---------------------------------------------------------------------------
// Bytes of a terminal color reply enter on the slave stream one beat per
// cycle; the parser searches for the first "rgb:" and then reads red and
// green fields ending in '/' and a blue field ending in ESC, each of one to
// four hex digits that are left-aligned into 16-bit fractions. The beat that
// carries tlast ends the reply: it is parsed like any other, the parser
// rearms for the next reply at once, and exactly one result beat follows on
// the master stream. Its tuser is the shade (none, dark or light) and its
// tdata the Q16 luma 0.2126 R + 0.7152 G + 0.0722 B, truncated, which is zero
// when the shade is none; light means luma of at least one half. Any
// malformed, empty or overlong field, a NUL before the color is complete, or
// a reply that ends before blue's ESC gives none, and bytes after the ESC
// are ignored. The parser takes one byte every cycle, limited only by room
// in its two-entry result queue, and each result leaves the luma pipeline
// (a product stage followed by a sum and threshold stage) on the master
// stream. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------

module background_color_reply_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] reply_byte
  input  logic        s_axis_tlast_i,   // end_of_reply
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] luma
  output logic [1:0]  m_axis_tuser_o    // [1:0] shade
);

  logic                  fifo_space;
  logic                  push;
  bcrp_pkg::bcrp_color_t push_data;
  logic                  fifo_valid;
  bcrp_pkg::bcrp_color_t fifo_data;
  logic                  pop;
  bcrp_pkg::bcrp_shade_e shade;

  // Parser: one byte per beat, hands a finished color to the queue.
  bcrp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (s_axis_tvalid_i),
    .byte_ready_o   (s_axis_tready_o),
    .reply_byte_i   (s_axis_tdata_i),
    .end_of_reply_i (s_axis_tlast_i),
    .space_i        (fifo_space),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  // Queue lets the parser keep taking bytes while a result is stalled.
  bcrp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .space_o     (fifo_space),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .pop_data_o  (fifo_data)
  );

  // Luma pipeline with a registered output beat.
  bcrp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (fifo_valid),
    .item_i       (fifo_data),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_shade_o  (shade),
    .out_luma_o   (m_axis_tdata_o)
  );

  assign m_axis_tuser_o = shade;

endmodule
